>>> rtl/gld_pkg.sv
// Shared constants, codes and types of the GIF LZW decoder.
// No dependencies; gld_front, gld_core and gif_lzw_decoder import this package.
package gld_pkg;

    localparam int DICT_DEPTH  = 4096;
    localparam int DICT_AW     = $clog2(DICT_DEPTH);
    localparam int STACK_DEPTH = DICT_DEPTH + 1;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int CODE_W      = 12;
    localparam int NFC_W       = 13;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_PUSH  = 2'd1;
    localparam logic [1:0] CMD_PULL  = 2'd2;
    localparam logic [1:0] CMD_END   = 2'd3;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_REJECTED = 3'd1;
    localparam logic [2:0] ST_PIXEL    = 3'd2;
    localparam logic [2:0] ST_NEED     = 3'd3;
    localparam logic [2:0] ST_FILLER   = 3'd4;
    localparam logic [2:0] ST_FINISHED = 3'd5;

    localparam logic [3:0] MIN_SIZE_LO  = 4'd2;
    localparam logic [3:0] MIN_SIZE_HI  = 4'd8;
    localparam logic [3:0] MIN_SIZE_RST = 4'd8;

    localparam logic [2:0] ADDR_MIN_SIZE = 3'd0;
    localparam logic [2:0] ADDR_PIX_CNT  = 3'd4;

    typedef enum logic [1:0] {
        K_START,
        K_PUSH,
        K_PULL,
        K_END
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
    } t_item;

endpackage

>>> rtl/gld_if.sv
// Valid/ready channel interfaces for the decoder's item and result streams.
// Depends on nothing.
interface gld_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;
    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface gld_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic [2:0] status;
    modport source (output valid, output pixel, output status, input ready);
    modport sink   (input valid, input pixel, input status, output ready);
endinterface

>>> rtl/gld_front.sv
// Front end: accepts command transactions, classifies them and queues them.
// Depends on gld_pkg and gld_in_if.
module gld_front
    import gld_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    gld_in_if.sink    i_item,
    output logic      o_q_valid,
    output t_item     o_q_item,
    input  logic      i_q_ready
);

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_push, w_pop;

    always_comb begin
        case (i_item.cmd)
            CMD_START: w_item.kind = K_START;
            CMD_PUSH:  w_item.kind = K_PUSH;
            CMD_PULL:  w_item.kind = K_PULL;
            CMD_END:   w_item.kind = K_END;
            default:   w_item.kind = K_PULL;
        endcase
        w_item.data_byte = i_item.data_byte;
    end

    assign i_item.ready = (r_cnt != 2'd2);
    assign w_push       = i_item.valid & i_item.ready;
    assign o_q_valid    = (r_cnt != 2'd0);
    assign o_q_item     = r_mem[r_rp];
    assign w_pop        = o_q_valid & i_q_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

>>> rtl/gld_core.sv
// Back end: runs queued commands against the bit buffer, dictionary and pixel stack.
// Depends on gld_pkg and gld_out_if; drives the registered result.
module gld_core
    import gld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [3:0]  i_min_code_size,
    input  logic [31:0] i_pixel_count,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_ready,
    gld_out_if.source   o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CODE,
        S_FIRST_RD,
        S_FIRST_WB,
        S_CHAIN,
        S_CHAIN_WB,
        S_POP,
        S_POP_WB
    } t_state;

    t_state                r_state, n_state;
    logic [STACK_AW-1:0]   r_top, n_top;
    logic [31:0]           r_buf, n_buf;
    logic [5:0]            r_held, n_held;
    logic [3:0]            r_width, n_width;
    logic [3:0]            r_size, n_size;
    logic [NFC_W-1:0]      r_nfc, n_nfc;
    logic [CODE_W-1:0]     r_prev, n_prev;
    logic                  r_prev_valid, n_prev_valid;
    logic [7:0]            r_first, n_first;
    logic [31:0]           r_delivered, n_delivered;
    logic                  r_stopped, n_stopped;
    logic                  r_ended, n_ended;
    logic [CODE_W-1:0]     r_code, n_code;
    logic [CODE_W-1:0]     r_in_code, n_in_code;
    logic [NFC_W-1:0]      r_guard, n_guard;
    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_out_pixel, n_out_pixel;
    logic [2:0]            r_out_status, n_out_status;

    logic [CODE_W+7:0]     r_dict [DICT_DEPTH];
    logic [CODE_W+7:0]     r_dict_q;
    logic [7:0]            r_stack [STACK_DEPTH];
    logic [7:0]            r_stk_q;

    logic                  w_dict_we;
    logic [DICT_AW-1:0]    w_dict_wa, w_dict_ra;
    logic [CODE_W+7:0]     w_dict_wd;
    logic                  w_push;
    logic [7:0]            w_push_val;
    logic [STACK_AW-1:0]   w_stk_ra;
    logic                  w_stk_we;

    logic [3:0]            w_size;
    logic [NFC_W-1:0]      w_clear;
    logic [31:0]           w_mask32;
    logic [NFC_W-1:0]      w_mask13;
    logic [CODE_W-1:0]     w_code;
    logic [NFC_W-1:0]      w_code13;
    logic [NFC_W-1:0]      w_nfc_inc;

    assign o_result.valid  = r_out_valid;
    assign o_result.pixel  = r_out_pixel;
    assign o_result.status = r_out_status;

    always_comb begin
        if (i_min_code_size < MIN_SIZE_LO) begin
            w_size = MIN_SIZE_LO;
        end else if (i_min_code_size > MIN_SIZE_HI) begin
            w_size = MIN_SIZE_HI;
        end else begin
            w_size = i_min_code_size;
        end
    end

    assign w_clear   = NFC_W'(1) << r_size;
    assign w_mask32  = (32'd1 << r_width) - 32'd1;
    assign w_mask13  = (NFC_W'(1) << r_width) - NFC_W'(1);
    assign w_code    = CODE_W'(r_buf & w_mask32);
    assign w_code13  = {1'b0, w_code};
    assign w_nfc_inc = r_nfc + NFC_W'(1);

    always_comb begin
        n_state      = r_state;
        n_top        = r_top;
        n_buf        = r_buf;
        n_held       = r_held;
        n_width      = r_width;
        n_size       = r_size;
        n_nfc        = r_nfc;
        n_prev       = r_prev;
        n_prev_valid = r_prev_valid;
        n_first      = r_first;
        n_delivered  = r_delivered;
        n_stopped    = r_stopped;
        n_ended      = r_ended;
        n_code       = r_code;
        n_in_code    = r_in_code;
        n_guard      = r_guard;
        n_out_valid  = r_out_valid & ~o_result.ready;
        n_out_pixel  = r_out_pixel;
        n_out_status = r_out_status;
        o_q_ready    = 1'b0;
        w_dict_we    = 1'b0;
        w_dict_wa    = r_nfc[DICT_AW-1:0];
        w_dict_wd    = {r_prev, r_first};
        w_dict_ra    = r_code[DICT_AW-1:0];
        w_push       = 1'b0;
        w_push_val   = 8'd0;
        w_stk_ra     = r_top - STACK_AW'(1);

        case (r_state)
            S_IDLE: begin
                if (i_q_valid && !r_out_valid) begin
                    o_q_ready    = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_pixel  = 8'd0;
                    n_out_status = ST_ACCEPTED;
                    case (i_q_item.kind)
                        K_START: begin
                            n_size       = w_size;
                            n_width      = w_size + 4'd1;
                            n_nfc        = (NFC_W'(1) << w_size) + NFC_W'(2);
                            n_prev       = '0;
                            n_prev_valid = 1'b0;
                            n_first      = 8'd0;
                            n_buf        = 32'd0;
                            n_held       = 6'd0;
                            n_top        = '0;
                            n_delivered  = 32'd0;
                            n_stopped    = 1'b0;
                            n_ended      = 1'b0;
                        end
                        K_PUSH: begin
                            if (!r_ended && !r_stopped) begin
                                if (r_held > 6'd24) begin
                                    n_out_status = ST_REJECTED;
                                end else begin
                                    n_buf  = r_buf | (32'(i_q_item.data_byte) << r_held);
                                    n_held = r_held + 6'd8;
                                end
                            end
                        end
                        K_END: begin
                            n_ended = 1'b1;
                        end
                        K_PULL: begin
                            if (r_delivered >= i_pixel_count) begin
                                n_out_status = ST_FINISHED;
                            end else if (r_stopped) begin
                                n_out_status = ST_FILLER;
                                n_delivered  = r_delivered + 32'd1;
                            end else begin
                                // hold the result until decoding finishes
                                n_out_valid = 1'b0;
                                n_state     = (r_top != '0) ? S_POP : S_CODE;
                            end
                        end
                        default: begin
                            n_out_status = ST_ACCEPTED;
                        end
                    endcase
                end
            end
            S_CODE: begin
                if (r_held < {2'b00, r_width}) begin
                    n_out_valid  = 1'b1;
                    n_out_pixel  = 8'd0;
                    n_state      = S_IDLE;
                    if (r_ended) begin
                        n_stopped    = 1'b1;
                        n_out_status = ST_FILLER;
                        n_delivered  = r_delivered + 32'd1;
                    end else begin
                        n_out_status = ST_NEED;
                    end
                end else begin
                    n_buf  = r_buf >> r_width;
                    n_held = r_held - {2'b00, r_width};
                    if (w_code13 > r_nfc || w_code13 == w_clear + NFC_W'(1)) begin
                        n_stopped    = 1'b1;
                        n_out_valid  = 1'b1;
                        n_out_pixel  = 8'd0;
                        n_out_status = ST_FILLER;
                        n_delivered  = r_delivered + 32'd1;
                        n_state      = S_IDLE;
                    end else if (w_code13 == w_clear) begin
                        n_width      = r_size + 4'd1;
                        n_nfc        = w_clear + NFC_W'(2);
                        n_prev_valid = 1'b0;
                    end else if (!r_prev_valid) begin
                        n_prev       = w_code;
                        n_prev_valid = 1'b1;
                        n_first      = w_code[7:0];
                        if (w_code13 < w_clear) begin
                            w_push     = 1'b1;
                            w_push_val = w_code[7:0];
                            n_state    = S_POP;
                        end else begin
                            n_code  = w_code;
                            n_state = S_FIRST_RD;
                        end
                    end else begin
                        n_in_code = w_code;
                        n_guard   = '0;
                        n_code    = w_code;
                        // code not yet in the table: repeat the first character
                        if (w_code13 == r_nfc) begin
                            w_push     = 1'b1;
                            w_push_val = r_first;
                            n_code     = r_prev;
                        end
                        n_state = S_CHAIN;
                    end
                end
            end
            S_FIRST_RD: begin
                n_state = S_FIRST_WB;
            end
            S_FIRST_WB: begin
                w_push     = 1'b1;
                w_push_val = r_dict_q[7:0];
                n_state    = S_POP;
            end
            S_CHAIN: begin
                if ({1'b0, r_code} > w_clear && r_guard < NFC_W'(DICT_DEPTH)) begin
                    n_state = S_CHAIN_WB;
                end else begin
                    n_first = r_code[7:0];
                    if (r_nfc >= NFC_W'(DICT_DEPTH)) begin
                        // dictionary full: drop pending pixels and stop
                        n_top        = '0;
                        n_stopped    = 1'b1;
                        n_out_valid  = 1'b1;
                        n_out_pixel  = 8'd0;
                        n_out_status = ST_FILLER;
                        n_delivered  = r_delivered + 32'd1;
                        n_state      = S_IDLE;
                    end else begin
                        w_push     = 1'b1;
                        w_push_val = r_code[7:0];
                        w_dict_we  = 1'b1;
                        w_dict_wd  = {r_prev, r_code[7:0]};
                        n_nfc      = w_nfc_inc;
                        if ((w_nfc_inc & w_mask13) == '0 &&
                            w_nfc_inc < NFC_W'(DICT_DEPTH)) begin
                            n_width = r_width + 4'd1;
                        end
                        n_prev  = r_in_code;
                        n_state = S_POP;
                    end
                end
            end
            S_CHAIN_WB: begin
                w_push     = 1'b1;
                w_push_val = r_dict_q[7:0];
                n_code     = r_dict_q[CODE_W+7:8];
                n_guard    = r_guard + NFC_W'(1);
                n_state    = S_CHAIN;
            end
            S_POP: begin
                n_top   = r_top - STACK_AW'(1);
                n_state = S_POP_WB;
            end
            S_POP_WB: begin
                n_out_valid  = 1'b1;
                n_out_pixel  = r_stk_q;
                n_out_status = ST_PIXEL;
                n_delivered  = r_delivered + 32'd1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // drop pushes beyond the stack capacity
        w_stk_we = w_push && (r_top < STACK_AW'(STACK_DEPTH));
        if (w_stk_we) begin
            n_top = r_top + STACK_AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dict_we) begin
            r_dict[w_dict_wa] <= w_dict_wd;
        end
        r_dict_q <= r_dict[w_dict_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            r_stack[r_top] <= w_push_val;
        end
        r_stk_q <= r_stack[w_stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_top        <= '0;
            r_buf        <= 32'd0;
            r_held       <= 6'd0;
            r_size       <= MIN_SIZE_RST;
            r_width      <= MIN_SIZE_RST + 4'd1;
            r_nfc        <= (NFC_W'(1) << MIN_SIZE_RST) + NFC_W'(2);
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_first      <= 8'd0;
            r_delivered  <= 32'd0;
            r_stopped    <= 1'b0;
            r_ended      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_top        <= n_top;
            r_buf        <= n_buf;
            r_held       <= n_held;
            r_size       <= n_size;
            r_width      <= n_width;
            r_nfc        <= n_nfc;
            r_prev       <= n_prev;
            r_prev_valid <= n_prev_valid;
            r_first      <= n_first;
            r_delivered  <= n_delivered;
            r_stopped    <= n_stopped;
            r_ended      <= n_ended;
            r_out_valid  <= n_out_valid;
        end
        r_code       <= n_code;
        r_in_code    <= n_in_code;
        r_guard      <= n_guard;
        r_out_pixel  <= n_out_pixel;
        r_out_status <= n_out_status;
    end

endmodule

>>> rtl/gif_lzw_decoder.sv
// GIF LZW decoder top level: APB register block, command queue and decode engine.
// Depends on gld_pkg, gld_if, gld_front and gld_core.
//
// Usage: commands arrive on i_item (valid/ready): start image, push one
// compressed byte, pull one pixel, mark end of data. Every command
// transaction yields exactly one result transaction on o_result, carrying
// a pixel and a status code. The user must write min_code_size and pixel_count
// over the APB port only while the block is idle; the block does not enforce
// this. min_code_size takes effect at the next start command.
// Start, push, end and pulls answered as finished or filler are answered
// straight from the idle state; a pull served from the pixel stack passes
// through the stack memory read (pop, then write-back of the read pixel).
// A pull that decodes reaches the engine through the command queue, reads
// codes, reads the dictionary for a first code above the literals, walks
// the prefix chain one dictionary entry at a time (memory read then push),
// adds the entry, then does the stack read. The engine takes a new command
// only once its result register is empty.
// Reset loads min code size 8 and an empty image; the dictionary needs no
// clearing pass. When the receiver stalls, the result register holds and
// the queue keeps taking commands until it is full.
module gif_lzw_decoder
    import gld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    gld_in_if.sink      i_item,
    gld_out_if.source   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0]  r_min_code_size;
    logic [31:0] r_pixel_count;
    logic        w_q_valid, w_q_ready;
    t_item       w_q_item;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_code_size <= MIN_SIZE_RST;
            r_pixel_count   <= 32'd0;
        end else if (w_wr) begin
            if (paddr[2] == ADDR_PIX_CNT[2]) begin
                r_pixel_count <= pwdata;
            end else begin
                r_min_code_size <= pwdata[3:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == ADDR_MIN_SIZE[2]) begin
            prdata = {28'd0, r_min_code_size};
        end else begin
            prdata = r_pixel_count;
        end
    end

    gld_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_ready (w_q_ready)
    );

    gld_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_min_code_size (r_min_code_size),
        .i_pixel_count   (r_pixel_count),
        .i_q_valid       (w_q_valid),
        .i_q_item        (w_q_item),
        .o_q_ready       (w_q_ready),
        .o_result        (o_result)
    );

endmodule
